// ----- sv/salru_pkg.sv -----
package salru_pkg;

  localparam int MaxSets    = 256;
  localparam int MaxWays    = 8;
  localparam int SetW       = $clog2(MaxSets);
  localparam int WayW       = $clog2(MaxWays);
  localparam int AddrW      = 64;
  localparam int TagW       = 64;
  localparam int StampW     = 32;
  localparam int CntW       = 32;
  localparam int OpW        = 2;
  localparam int OutcomeW   = 2;
  localparam int SetBitsW   = 4;
  localparam int WaysW      = 4;
  localparam int BlockBitsW = 6;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 6;

  typedef enum logic [OpW-1:0] {
    OpLoad,
    OpStore,
    OpModify,
    OpFetch
  } op_e;

  typedef enum logic [OutcomeW-1:0] {
    OutHit,
    OutFill,
    OutEvict
  } outcome_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSetBits,
    CfgWays,
    CfgBlockBits
  } cfg_idx_e;

  typedef struct packed {
    logic [MaxWays-1:0]             valid;
    logic [MaxWays-1:0][TagW-1:0]   tag;
    logic [MaxWays-1:0][StampW-1:0] stamp;
  } row_t;

  typedef struct packed {
    outcome_e        outcome;
    logic [WayW-1:0] way;
  } sel_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ----- sv/salru_req_if.sv -----
interface salru_req_if;
  import salru_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [AddrW-1:0] address;

  modport source (output valid, op, address, input ready);
  modport sink (input valid, op, address, output ready);

endinterface

// ----- sv/salru_rsp_if.sv -----
interface salru_rsp_if;
  import salru_pkg::*;

  logic                valid;
  logic                ready;
  logic [OutcomeW-1:0] outcome;
  logic [CntW-1:0]     hits_total;
  logic [CntW-1:0]     misses_total;
  logic [CntW-1:0]     evictions_total;
  logic                last;

  modport source (
    output valid, outcome, hits_total, misses_total, evictions_total, last,
    input ready
  );
  modport sink (
    input valid, outcome, hits_total, misses_total, evictions_total, last,
    output ready
  );

endinterface

// ----- sv/salru_way_sel.sv -----
module salru_way_sel (
  input  salru_pkg::row_t                  row_i,
  input  logic [salru_pkg::TagW-1:0]       tag_i,
  input  logic [salru_pkg::WaysW-1:0]      ways_i,
  output salru_pkg::sel_t                  sel_o
);
  import salru_pkg::*;

  typedef struct packed {
    logic              cand;
    logic [StampW-1:0] stamp;
    logic [WayW-1:0]   way;
  } node_t;

  function automatic node_t pick(input node_t l, input node_t r);
    if (!r.cand) return l;
    if (!l.cand) return r;
    return (r.stamp < l.stamp) ? r : l;
  endfunction

  logic [MaxWays-1:0] in_use;
  logic [MaxWays-1:0] hit_vec;
  logic [MaxWays-1:0] free_vec;
  logic [WayW-1:0]    hit_way;
  logic [WayW-1:0]    free_way;
  node_t              tree [2*MaxWays-1];

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < MaxWays; w++) begin
      in_use[w]   = ways_i > WaysW'(w);
      hit_vec[w]  = in_use[w] && row_i.valid[w] && (row_i.tag[w] == tag_i);
      free_vec[w] = in_use[w] && !row_i.valid[w];
    end
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WayW'(w);
      if (free_vec[w]) free_way = WayW'(w);
    end
  end

  // lowest stamp, lower way wins ties
  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      tree[MaxWays-1+w].cand  = in_use[w];
      tree[MaxWays-1+w].stamp = row_i.stamp[w];
      tree[MaxWays-1+w].way   = WayW'(w);
    end
    for (int n = MaxWays - 2; n >= 0; n--) begin
      tree[n] = pick(tree[2*n+1], tree[2*n+2]);
    end
  end

  always_comb begin
    if (|hit_vec) begin
      sel_o.outcome = OutHit;
      sel_o.way     = hit_way;
    end else if (|free_vec) begin
      sel_o.outcome = OutFill;
      sel_o.way     = free_way;
    end else begin
      sel_o.outcome = OutEvict;
      sel_o.way     = tree[0].way;
    end
  end

endmodule

// ----- sv/set_assoc_cache_lru_tag_store.sv -----
// a load or store reads its set row into a register, then loads its result into the
// output register once that is free; a modify gives two results, a fetch gives none
// a new load, store or modify is taken only after the last one's final row write-back;
// fetches are taken one per cycle while idle; reset: counters and stamp clear at once, then
// a pass over all 256 sets clears the valid bits of every set before the first request is taken
module set_assoc_cache_lru_tag_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [salru_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [salru_pkg::CfgDataW-1:0]   cfg_data_i,
  salru_req_if.sink                        req_i,
  salru_rsp_if.source                      rsp_o
);
  import salru_pkg::*;

  localparam logic [1:0] StClr  = 2'd0;
  localparam logic [1:0] StIdle = 2'd1;
  localparam logic [1:0] StAcc  = 2'd2;
  localparam int TagShW = BlockBitsW + 1;

  logic [1:0]            state_q, state_d;
  logic [SetW-1:0]       clr_idx_q;
  logic [SetBitsW-1:0]   set_bits_q;
  logic [WaysW-1:0]      ways_q;
  logic [BlockBitsW-1:0] block_bits_q;
  logic [StampW-1:0]     stamp_q;
  logic [CntW-1:0]       hits_q, misses_q, evicts_q;
  logic                  second_q;
  logic                  out_valid_q;
  outcome_e              outcome_q;
  logic                  last_q;
  logic [SetW-1:0]       set_q;
  logic [TagW-1:0]       tag_q;
  row_t                  row_q;
  row_t                  mem [MaxSets];

  logic [AddrW-1:0]  off_shift;
  logic [SetW-1:0]   set_mask;
  logic [SetW-1:0]   set_d;
  logic [TagShW-1:0] tag_shift;
  logic [TagW-1:0]   tag_d;
  logic [WaysW-1:0]  ways_eff;
  logic              req_fire;
  logic              rd_en;
  logic              can_out;
  logic              acc_fire;
  sel_t              sel;
  row_t              new_row;
  logic              mem_we;
  logic [SetW-1:0]   mem_waddr;
  row_t              mem_wdata;

  assign off_shift = req_i.address >> block_bits_q;
  assign set_mask  = ~({SetW{1'b1}} << set_bits_q);
  assign set_d     = off_shift[SetW-1:0] & set_mask;
  assign tag_shift = TagShW'(block_bits_q) + TagShW'(set_bits_q);
  assign tag_d     = req_i.address >> tag_shift;

  always_comb begin
    if (ways_q == '0) begin
      ways_eff = WaysW'(1);
    end else if (ways_q > WaysW'(MaxWays)) begin
      ways_eff = WaysW'(MaxWays);
    end else begin
      ways_eff = ways_q;
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rd_en       = req_fire && (req_i.op != OpFetch);
  assign can_out     = !out_valid_q || rsp_o.ready;
  assign acc_fire    = (state_q == StAcc) && can_out;

  salru_way_sel u_way_sel (
    .row_i  (row_q),
    .tag_i  (tag_q),
    .ways_i (ways_eff),
    .sel_o  (sel)
  );

  always_comb begin
    new_row                = row_q;
    new_row.valid[sel.way] = 1'b1;
    new_row.tag[sel.way]   = tag_q;
    new_row.stamp[sel.way] = stamp_q;
  end

  assign mem_we    = (state_q == StClr) || acc_fire;
  assign mem_waddr = (state_q == StClr) ? clr_idx_q : set_q;
  assign mem_wdata = (state_q == StClr) ? '0 : new_row;

  // set row memory, second access of a modify takes the updated row directly
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      row_q <= mem[set_d];
    end else if (acc_fire && second_q) begin
      row_q <= new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
    if (acc_fire) begin
      outcome_q <= sel.outcome;
      last_q    <= !second_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClr: begin
        if (clr_idx_q == {SetW{1'b1}}) state_d = StIdle;
      end
      StIdle: begin
        if (rd_en) state_d = StAcc;
      end
      StAcc: begin
        if (acc_fire && !second_q) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClr;
      clr_idx_q    <= '0;
      set_bits_q   <= SetBitsW'(4);
      ways_q       <= WaysW'(1);
      block_bits_q <= BlockBitsW'(4);
      stamp_q      <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
      second_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClr) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgSetBits:   set_bits_q   <= cfg_data_i[SetBitsW-1:0];
          CfgWays:      ways_q       <= cfg_data_i[WaysW-1:0];
          CfgBlockBits: block_bits_q <= cfg_data_i[BlockBitsW-1:0];
          default: ;
        endcase
      end
      if (req_fire) begin
        stamp_q <= sat_inc(stamp_q);
      end
      if (rd_en) begin
        second_q <= (req_i.op == OpModify);
      end else if (acc_fire) begin
        second_q <= 1'b0;
      end
      if (acc_fire) begin
        case (sel.outcome)
          OutHit: hits_q <= sat_inc(hits_q);
          OutFill: misses_q <= sat_inc(misses_q);
          default: begin
            misses_q <= sat_inc(misses_q);
            evicts_q <= sat_inc(evicts_q);
          end
        endcase
      end
      if (acc_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // totals only move when a new result is loaded, so they serve as the payload
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.outcome         = outcome_q;
  assign rsp_o.hits_total      = hits_q;
  assign rsp_o.misses_total    = misses_q;
  assign rsp_o.evictions_total = evicts_q;
  assign rsp_o.last            = last_q;

endmodule

// ----- sv/salru_chk.sv -----
module salru_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic [salru_pkg::OpW-1:0]       req_op_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [salru_pkg::OutcomeW-1:0]  rsp_outcome_i,
  input logic [salru_pkg::CntW-1:0]      rsp_hits_i,
  input logic [salru_pkg::CntW-1:0]      rsp_misses_i,
  input logic [salru_pkg::CntW-1:0]      rsp_evictions_i,
  input logic                            rsp_last_i
);
  import salru_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_outcome_i)
      && $stable(rsp_hits_i) && $stable(rsp_misses_i) && $stable(rsp_evictions_i)
      && $stable(rsp_last_i))
    else $error("response changed while stalled");

  a_evict_le_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_evictions_i <= rsp_misses_i)
    else $error("evictions exceed misses");

  a_modify_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_op_i == OpModify) |=> !req_ready_i)
    else $error("request taken during modify");

  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_outcome_i == OutHit) |-> rsp_hits_i != '0)
    else $error("hit reported with zero hit total");

endmodule

bind set_assoc_cache_lru_tag_store salru_chk u_salru_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_op_i        (req_i.op),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_outcome_i   (rsp_o.outcome),
  .rsp_hits_i      (rsp_o.hits_total),
  .rsp_misses_i    (rsp_o.misses_total),
  .rsp_evictions_i (rsp_o.evictions_total),
  .rsp_last_i      (rsp_o.last)
);
